// File: sv/positional_ordered_list_defines.svh
// Assertion macros shared by the checker
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// same-cycle implication
`define POL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pol_pkg.sv
package pol_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
  localparam int DATA_W   = 32;

  localparam logic [2:0] CMD_INS_HEAD = 3'd0;
  localparam logic [2:0] CMD_INS_TAIL = 3'd1;
  localparam logic [2:0] CMD_INS_POS  = 3'd2;
  localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
  localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
  localparam logic [2:0] CMD_DEL_POS  = 3'd5;
  localparam logic [2:0] CMD_LENGTH   = 3'd6;
  localparam logic [2:0] CMD_DISPLAY  = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     last_idx;
  } cell_ctrl_t;

endpackage

// File: sv/pol_cell.sv
module pol_cell
  import pol_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]         my_idx,
  input  logic signed [DATA_W-1:0] ins_value,
  input  logic signed [DATA_W-1:0] head_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value
);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.op)
      OP_HOLD: val_nxt = val_r;
      OP_INS: begin
        if (my_idx == ctrl.idx) begin
          val_nxt = ins_value;
        end else if (my_idx > ctrl.idx) begin
          val_nxt = left_value;
        end
      end
      OP_DEL: begin
        if (my_idx >= ctrl.idx) begin
          val_nxt = right_value;
        end
      end
      OP_ROT: begin
        if (my_idx == ctrl.last_idx) begin
          val_nxt = head_value;
        end else if (my_idx < ctrl.last_idx) begin
          val_nxt = right_value;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign value = val_r;

endmodule

// File: sv/positional_ordered_list.sv
// Bounded ordered list of signed 32-bit words, one command word in, result words out.
// Input channel: in_command, in_value, in_position, with in_valid / in_stall.
// Result channel: out_status, out_item_value, out_length, out_last, with out_valid /
// out_stall. Every command gives one result word with out_last set, except a display of a
// non-empty list, which gives one word per entry, head first, the last one marked.
// Storage is a row of cells, one entry each; inserts and deletes shift every cell from the
// given position on at once, and the result word is on the output in the cycle after the
// command is accepted. While out_stall stays low and no display runs, a new command is
// taken every cycle.
// Display rotates the row through the head, one word per cycle while out_stall stays low;
// its first word comes later than that of a plain command, as it first enters the display
// state. It holds the input until its last word, and the row is back in order when it ends.
// Reset (rst_n low at a clock edge) empties the list and drops any pending result.
// A stalled result word holds; while it waits, new commands are stalled and a
// display pauses with it.
module positional_ordered_list
  import pol_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_item_value,
  output logic [LEN_W-1:0]         out_length,
  output logic                     out_last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DISP = 1'b1;

  logic                     state_r;
  logic [LEN_W-1:0]         count_r;
  logic [LEN_W-1:0]         count_nxt;
  logic [LEN_W-1:0]         rem_r;
  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic signed [DATA_W-1:0] out_item_r;
  logic [LEN_W-1:0]         out_length_r;
  logic                     out_last_r;

  logic                     slot_free;
  logic                     in_fire;
  logic                     disp_go;
  logic                     start_disp;
  logic [1:0]               status_c;
  cell_op_t                 upd_op;
  logic [IDX_W-1:0]         upd_idx;
  cell_ctrl_t               ctrl;
  logic                     full;
  logic                     empty;
  logic [CMP_W-1:0]         pos_x;
  logic [CMP_W-1:0]         cnt_x;
  logic [POS_W-1:0]         pos_m1;
  logic [LEN_W-1:0]         cnt_m1;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == S_DISP) || !slot_free;
  assign in_fire   = in_valid && !in_stall;
  assign disp_go   = (state_r == S_DISP) && slot_free;

  assign full   = (count_r == LEN_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign pos_x  = CMP_W'(in_position);
  assign cnt_x  = CMP_W'(count_r);
  assign pos_m1 = in_position - 1'b1;
  assign cnt_m1 = count_r - 1'b1;

  always_comb begin
    status_c   = ST_OK;
    upd_op     = OP_HOLD;
    upd_idx    = '0;
    count_nxt  = count_r;
    start_disp = 1'b0;
    unique case (in_command)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          upd_op    = OP_INS;
          upd_idx   = (in_command == CMD_INS_HEAD) ? '0 : count_r[IDX_W-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_INS_POS: begin
        if (in_position == '0 || pos_x > cnt_x + 1'b1) begin
          status_c = ST_BADPOS;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          upd_op    = OP_INS;
          upd_idx   = pos_m1[IDX_W-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          upd_op    = OP_DEL;
          upd_idx   = (in_command == CMD_DEL_HEAD) ? '0 : cnt_m1[IDX_W-1:0];
          count_nxt = cnt_m1;
        end
      end
      CMD_DEL_POS: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else if (in_position == '0 || pos_x > cnt_x) begin
          status_c = ST_BADPOS;
        end else begin
          upd_op    = OP_DEL;
          upd_idx   = pos_m1[IDX_W-1:0];
          count_nxt = cnt_m1;
        end
      end
      CMD_LENGTH: status_c = ST_OK;
      CMD_DISPLAY: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          start_disp = 1'b1;
        end
      end
      default: status_c = ST_OK;
    endcase
  end

  always_comb begin
    ctrl.idx      = upd_idx;
    ctrl.last_idx = cnt_m1[IDX_W-1:0];
    if (in_fire) begin
      ctrl.op = upd_op;
    end else if (disp_go) begin
      ctrl.op = OP_ROT;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = in_value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    pol_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .my_idx      (IDX_W'(i)),
      .ins_value   (in_value),
      .head_value  (cell_val[0]),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_fire && !start_disp) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_c;
        out_item_r   <= '0;
        out_length_r <= count_nxt;
        out_last_r   <= 1'b1;
      end else if (in_fire && start_disp) begin
        state_r     <= S_DISP;
        rem_r       <= count_r;
        out_valid_r <= 1'b0;
      end else if (disp_go) begin
        out_valid_r  <= 1'b1;
        out_status_r <= ST_OK;
        out_item_r   <= cell_val[0];
        out_length_r <= count_r;
        out_last_r   <= (rem_r == LEN_W'(1));
        rem_r        <= rem_r - 1'b1;
        if (rem_r == LEN_W'(1)) begin
          state_r <= S_IDLE;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_item_value = out_item_r;
  assign out_length     = out_length_r;
  assign out_last       = out_last_r;

endmodule

// File: sv/pol_checker.sv
`include "positional_ordered_list_defines.svh"

module pol_checker
  import pol_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [2:0]               in_command,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               out_status,
  input logic signed [DATA_W-1:0] out_item_value,
  input logic [LEN_W-1:0]         out_length,
  input logic                     out_last
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  `POL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item_value) && $stable(out_length) && $stable(out_status) && $stable(out_last), "stalled word changed")
  `POL_ASSERT_NEXT(a_cmd_result, in_acc && in_command != CMD_DISPLAY, out_valid && out_last, "command without single result")
  `POL_ASSERT_NOW(a_len_max, out_valid, out_length <= LEN_W'(CAPACITY), "length over capacity")
  `POL_ASSERT_NOW(a_empty_len, out_valid && out_status == ST_EMPTY, out_length == '0 && out_item_value == '0 && out_last, "bad empty status")
  `POL_ASSERT_NOW(a_full_len, out_valid && out_status == ST_FULL, out_length == LEN_W'(CAPACITY), "full status below capacity")

endmodule

bind positional_ordered_list pol_checker u_pol_checker (.*);

// File: test/positional_ordered_list_tb.sv
module positional_ordered_list_tb
  import pol_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 150;
  localparam int RANDOM_WORDS   = 400;
  localparam int PHASE_WORDS    = 30;

  typedef struct {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } cmd_word_t;

  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] item;
    logic [LEN_W-1:0]         len;
    logic                     fin;
  } result_word_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_command = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_item_value;
  logic [LEN_W-1:0]         out_length;
  logic                     out_last;

  positional_ordered_list dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_length     (out_length),
    .out_last       (out_last)
  );

  cmd_word_t                pending_cmds[$];
  result_word_t             due_results[$];
  logic signed [DATA_W-1:0] list_model[$];

  int plan_len;
  int n_cmds, n_results, n_errors, n_launched;
  int peak_len, n_full, n_badpos, n_empty;
  bit calm;
  bit in_took;
  int gap_left, stall_left, hold_left;
  bit held;
  int idle_cycles;
  cmd_word_t cur_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // queue a command word and track the list length it leaves behind
  function automatic void plan_cmd(logic [2:0] cmd, logic signed [DATA_W-1:0] value, int pos);
    cmd_word_t w;
    w.cmd   = cmd;
    w.value = value;
    w.pos   = pos[POS_W-1:0];
    pending_cmds.push_back(w);
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL: if (plan_len < CAPACITY) plan_len++;
      CMD_INS_POS:
        if (pos >= 1 && pos <= plan_len + 1 && plan_len < CAPACITY) plan_len++;
      CMD_DEL_HEAD, CMD_DEL_TAIL: if (plan_len > 0) plan_len--;
      CMD_DEL_POS: if (plan_len > 0 && pos >= 1 && pos <= plan_len) plan_len--;
      default: ;
    endcase
  endfunction

  function automatic int pick_pos(int hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (hi == 0 || r >= 94) return $urandom_range(0, 255);
    if (r < 80) return $urandom_range(1, hi);
    if (r < 88) return 0;
    return hi + 1;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic apply_list_cmd(logic [2:0] cmd, logic signed [DATA_W-1:0] value,
                                logic [POS_W-1:0] pos);
    result_word_t r;
    int p;
    int sz;
    p  = int'(pos);
    sz = list_model.size();
    r.status = ST_OK;
    r.item   = '0;
    r.fin    = 1'b1;
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL:
        if (sz >= CAPACITY) r.status = ST_FULL;
        else if (cmd == CMD_INS_HEAD) list_model.push_front(value);
        else list_model.push_back(value);
      CMD_INS_POS:
        if (p < 1 || p > sz + 1) r.status = ST_BADPOS;
        else if (sz >= CAPACITY) r.status = ST_FULL;
        else list_model.insert(p - 1, value);
      CMD_DEL_HEAD, CMD_DEL_TAIL:
        if (sz == 0) r.status = ST_EMPTY;
        else if (cmd == CMD_DEL_HEAD) void'(list_model.pop_front());
        else void'(list_model.pop_back());
      CMD_DEL_POS:
        if (sz == 0) r.status = ST_EMPTY;
        else if (p < 1 || p > sz) r.status = ST_BADPOS;
        else list_model.delete(p - 1);
      CMD_DISPLAY:
        if (sz == 0) r.status = ST_EMPTY;
        else begin
          for (int i = 0; i < sz; i++) begin
            r.item = list_model[i];
            r.len  = LEN_W'(sz);
            r.fin  = (i == sz - 1);
            due_results.push_back(r);
          end
          return;
        end
      default: ;
    endcase
    r.len = LEN_W'(list_model.size());
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_BADPOS) n_badpos++;
    if (r.status == ST_EMPTY) n_empty++;
    if (list_model.size() > peak_len) peak_len = list_model.size();
    due_results.push_back(r);
  endtask

  // driver: one command word on the bus, held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_cmds.size() > 0) begin
      cur_word = pending_cmds.pop_front();
      in_command  <= cur_word.cmd;
      in_value    <= cur_word.value;
      in_position <= cur_word.pos;
      in_valid    <= 1'b1;
      gap_left = idle_len();
      n_launched++;
      if (n_launched % 50 == 0) calm = ($urandom_range(0, 3) == 0);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!held && n_cmds >= HOLD_AFTER) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // monitor: check results first, then predict the command taken at this edge
  always @(posedge clk) begin : monitor
    result_word_t e;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (due_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result status %0d item %0d len %0d last %0d",
                   $time, out_status, out_item_value, out_length, out_last);
        end else begin
          e = due_results.pop_front();
          if (out_status !== e.status || out_item_value !== e.item ||
              out_length !== e.len || out_last !== e.fin) begin
            n_errors++;
            $display("%0t: mismatch exp status %0d item %0d len %0d last %0d",
                     $time, e.status, e.item, e.len, e.fin);
            $display("%0t:          got status %0d item %0d len %0d last %0d",
                     $time, out_status, out_item_value, out_length, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        n_cmds++;
        apply_list_cmd(in_command, in_value, in_position);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, due_results.size());
      $display("positional_ordered_list_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int ins_pct;
    int unsigned r;
    int mode;
    plan_len = 0;

    // directed: empty-list cases, extremes, position limits
    plan_cmd(CMD_DISPLAY, 0, 0);
    plan_cmd(CMD_DEL_HEAD, 0, 0);
    plan_cmd(CMD_DEL_TAIL, 0, 0);
    plan_cmd(CMD_DEL_POS, 0, 0);
    plan_cmd(CMD_LENGTH, 0, 0);
    plan_cmd(CMD_INS_POS, 32'sh1234_5678, 0);
    plan_cmd(CMD_INS_POS, 32'sh1234_5678, 2);
    plan_cmd(CMD_INS_POS, 32'sh8000_0000, 1);
    plan_cmd(CMD_INS_HEAD, 32'sh7fff_ffff, 0);
    plan_cmd(CMD_INS_TAIL, 32'sh0, 255);
    plan_cmd(CMD_INS_POS, -32'sd1, 4);
    plan_cmd(CMD_INS_POS, 32'sh5555_5555, 2);
    plan_cmd(CMD_DISPLAY, 0, 0);
    plan_cmd(CMD_DEL_POS, 0, 0);
    plan_cmd(CMD_DEL_POS, 0, 6);
    plan_cmd(CMD_DEL_POS, 0, 255);
    plan_cmd(CMD_INS_POS, 32'shaaaa_aaaa, 255);
    plan_cmd(CMD_DEL_POS, 0, 3);
    plan_cmd(CMD_DEL_POS, 0, 4);
    plan_cmd(CMD_DEL_TAIL, 0, 0);
    plan_cmd(CMD_DEL_HEAD, 0, 0);
    plan_cmd(CMD_LENGTH, 32'sh7fff_ffff, 255);
    plan_cmd(CMD_DISPLAY, 0, 0);
    plan_cmd(CMD_DEL_POS, 0, 1);
    plan_cmd(CMD_DISPLAY, 0, 0);

    // random: grow, grow, shrink, mixed phases so the list hits full and empty
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      mode = (i / PHASE_WORDS) % 4;
      ins_pct = (mode < 2) ? 85 : (mode == 2) ? 15 : 50;
      r = $urandom_range(0, 99);
      if (r < 6) plan_cmd(CMD_DISPLAY, pick_value(), $urandom_range(0, 255));
      else if (r < 10) plan_cmd(CMD_LENGTH, pick_value(), $urandom_range(0, 255));
      else if ($urandom_range(0, 99) < ins_pct) begin
        case ($urandom_range(0, 2))
          0: plan_cmd(CMD_INS_HEAD, pick_value(), $urandom_range(0, 255));
          1: plan_cmd(CMD_INS_TAIL, pick_value(), $urandom_range(0, 255));
          default: plan_cmd(CMD_INS_POS, pick_value(), pick_pos(plan_len + 1));
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: plan_cmd(CMD_DEL_HEAD, pick_value(), $urandom_range(0, 255));
          1: plan_cmd(CMD_DEL_TAIL, pick_value(), $urandom_range(0, 255));
          default: plan_cmd(CMD_DEL_POS, pick_value(), pick_pos(plan_len));
        endcase
      end
    end

    @(posedge rst_n);
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d commands, %0d result words checked, peak length %0d of %0d",
             n_cmds, n_results, peak_len, CAPACITY);
    $display("status hits: %0d full, %0d bad position, %0d empty; %0d errors",
             n_full, n_badpos, n_empty, n_errors);
    if (n_errors == 0) begin
      $display("positional_ordered_list_tb OK");
    end else begin
      $display("positional_ordered_list_tb NOT OK");
    end
    $finish;
  end

endmodule
